// File: src/cpp_pkg.sv
// Shared types, constants and the color rounding/packing function for the
// color palette block. No dependencies.
package cpp_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PSEUDO_DEPTH  = 16;
   localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int PSEUDO_W      = $clog2(PSEUDO_DEPTH);
   localparam int INDEX_W       = 9;
   localparam int CHAN_W        = 16;
   localparam int PACK_W        = 24;
   localparam int DEPTH_W       = 6;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 6;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd16;
   localparam logic [DEPTH_W-1:0] BPP_8  = 6'd8;
   localparam logic [DEPTH_W-1:0] BPP_16 = 6'd16;
   localparam logic [DEPTH_W-1:0] BPP_24 = 6'd24;
   localparam logic [DEPTH_W-1:0] BPP_32 = 6'd32;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_DEPTH = 2'd0,
      CSR_GRAY_MODE   = 2'd1,
      CSR_INVERT_GRAY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   typedef struct packed {
      rgb_type           stored;
      logic [PACK_W-1:0] packed_word;
      logic              packed_valid;
   } pack_type;

   // Round the channel bytes to the pixel depth and form the packed word; other depths clear packed_valid.
   function automatic pack_type pack_color(input logic [DEPTH_W-1:0] depth,
                                           input rgb_type c);
      pack_type p;
      p.stored       = c;
      p.packed_word  = '0;
      p.packed_valid = 1'b1;
      case (depth) inside
         BPP_8: begin
            p.stored.r    = {c.r[7:5], 5'b0};
            p.stored.g    = {c.g[7:5], 5'b0};
            p.stored.b    = {c.b[7:6], 6'b0};
            p.packed_word = {16'b0, c.r[7:5], c.g[7:5], c.b[7:6]};
         end
         BPP_16: begin
            p.stored.r    = {c.r[7:3], 3'b0};
            p.stored.g    = {c.g[7:2], 2'b0};
            p.stored.b    = {c.b[7:3], 3'b0};
            p.packed_word = {8'b0, c.r[7:3], c.g[7:2], c.b[7:3]};
         end
         BPP_24, BPP_32: begin
            p.packed_word = {c.r, c.g, c.b};
         end
         default: begin
            p.packed_valid = 1'b0;
         end
      endcase
      return p;
   endfunction

   // Byte doubled into both halves of a 16-bit channel.
   function automatic logic [CHAN_W-1:0] dup_byte(input logic [7:0] b);
      return {b, b};
   endfunction

endpackage

// File: src/cpp_store.sv
// Palette storage: 256 x 24-bit memory with a registered read port and
// per-entry valid bits so that never-written entries read as zero.
// Depends on cpp_pkg.
module cpp_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [cpp_pkg::ADDR_W-1:0] wr_addr,
   input  cpp_pkg::rgb_type      wr_data,
   input  logic                  rd_en,
   input  logic [cpp_pkg::ADDR_W-1:0] rd_addr,
   output cpp_pkg::rgb_type      rd_data
);
   import cpp_pkg::*;

   rgb_type                  mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] valid_ff;
   rgb_type                  rd_data_ff;
   logic                     rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   // unwritten entries read as zero through their cleared valid bit
   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

// File: src/color_palette_with_packing.sv
// Top level of the color palette with pixel packing.
// Depends on cpp_pkg and cpp_store.
//
// One request transfer is taken at each rising edge where start is high and
// busy is low; busy is high only while reset is asserted, so a new request
// can be issued every cycle. Each request produces exactly one response,
// presented for a single cycle with rsp_valid once it has passed the stage 1
// and result registers; the receiver cannot stall, so it must sample the
// response in that cycle. The request passes through the palette memory read
// (256 x 24, registered read port) and then through the result register.
// Writes update the palette at the request edge, so a read issued in the
// following cycle already sees the new entry. Entries never written read as
// zero through per-entry valid bits cleared by reset; there is no clearing
// pass. Indices above 255 return bad_index with every other field zero and
// change nothing. Configuration writes through the csr_ port take effect at
// once and are meant to be made while no request is in flight.
module color_palette_with_packing (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [cpp_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [cpp_pkg::CHAN_W-1:0]        req_red_in,
   input  logic [cpp_pkg::CHAN_W-1:0]        req_green_in,
   input  logic [cpp_pkg::CHAN_W-1:0]        req_blue_in,
   // response channel
   output logic                              rsp_valid,
   output logic                              rsp_bad_index,
   output logic [cpp_pkg::CHAN_W-1:0]        rsp_red_out,
   output logic [cpp_pkg::CHAN_W-1:0]        rsp_green_out,
   output logic [cpp_pkg::CHAN_W-1:0]        rsp_blue_out,
   output logic                              rsp_transp_out,
   output logic [cpp_pkg::PACK_W-1:0]        rsp_packed_word,
   output logic                              rsp_packed_valid,
   // configuration port
   input  logic                              csr_wr_en,
   input  logic [cpp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cpp_pkg::*;

   // ---------------- configuration registers ----------------
   logic [DEPTH_W-1:0] depth_ff;
   logic               gray_ff;
   logic               invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= DEPTH_RESET;
         gray_ff   <= 1'b0;
         invert_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIXEL_DEPTH: depth_ff  <= csr_wdata[DEPTH_W-1:0];
            CSR_GRAY_MODE:   gray_ff   <= csr_wdata[0];
            CSR_INVERT_GRAY: invert_ff <= csr_wdata[0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------- request stage ----------------
   logic              accept;
   logic              req_bad;
   logic              req_write;
   logic [ADDR_W-1:0] req_addr;
   rgb_type           req_color;
   pack_type          req_pack;
   logic              store_wr;
   logic              pseudo_wr;

   assign busy      = reset;
   assign accept    = start && !busy;
   // only the top index bit marks an out-of-range entry
   assign req_bad   = req_entry_index[INDEX_W-1];
   assign req_addr  = req_entry_index[ADDR_W-1:0];
   assign req_write = (action_type'(req_action) == ACT_WRITE);
   assign req_color = '{r: req_red_in[CHAN_W-1 -: 8],
                        g: req_green_in[CHAN_W-1 -: 8],
                        b: req_blue_in[CHAN_W-1 -: 8]};
   assign req_pack  = pack_color(depth_ff, req_color);
   assign store_wr  = accept && !req_bad && req_write;
   // pseudo-palette only covers the first 16 entries
   assign pseudo_wr = store_wr && req_pack.packed_valid &&
                      (req_addr[ADDR_W-1:PSEUDO_W] == '0);

   rgb_type rd_color;

   cpp_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_wr),
      .wr_addr (req_addr),
      .wr_data (req_pack.stored),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_color)
   );

   // pseudo-palette of packed pixel words
   logic [PACK_W-1:0] pseudo_ff [PSEUDO_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PSEUDO_DEPTH; i++) begin
            pseudo_ff[i] <= '0;
         end
      end else if (pseudo_wr) begin
         pseudo_ff[req_addr[PSEUDO_W-1:0]] <= req_pack.packed_word;
      end
   end

   // stage 1 registers: item in flight alongside the memory read
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_bad_ff;
   logic              s1_read_ff;
   logic [7:0]        s1_idx_ff;
   logic [PACK_W-1:0] s1_packed_ff;
   logic              s1_pvalid_ff;

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bad_ff    <= req_bad;
         s1_read_ff   <= !req_write;
         s1_idx_ff    <= req_entry_index[7:0];
         s1_packed_ff <= req_pack.packed_word;
         s1_pvalid_ff <= req_pack.packed_valid;
      end
   end

   // ---------------- result stage ----------------
   logic              rsp_valid_ff;
   logic              rsp_bad_ff, rsp_bad_in;
   logic [CHAN_W-1:0] rsp_red_ff, rsp_red_in;
   logic [CHAN_W-1:0] rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0] rsp_blue_ff, rsp_blue_in;
   logic [PACK_W-1:0] rsp_packed_ff, rsp_packed_in;
   logic              rsp_pvalid_ff, rsp_pvalid_in;
   logic [7:0]        gray_byte;

   assign gray_byte = s1_idx_ff ^ {8{invert_ff}};

   always_comb begin
      rsp_bad_in    = 1'b0;
      rsp_red_in    = '0;
      rsp_green_in  = '0;
      rsp_blue_in   = '0;
      rsp_packed_in = '0;
      rsp_pvalid_in = 1'b0;
      if (s1_bad_ff) begin
         rsp_bad_in = 1'b1;
      end else if (s1_read_ff) begin
         if (gray_ff) begin
            rsp_red_in   = dup_byte(gray_byte);
            rsp_green_in = dup_byte(gray_byte);
            rsp_blue_in  = dup_byte(gray_byte);
         end else begin
            rsp_red_in   = dup_byte(rd_color.r);
            rsp_green_in = dup_byte(rd_color.g);
            rsp_blue_in  = dup_byte(rd_color.b);
         end
      end else if (s1_pvalid_ff) begin
         rsp_packed_in = s1_packed_ff;
         rsp_pvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_bad_ff    <= rsp_bad_in;
         rsp_red_ff    <= rsp_red_in;
         rsp_green_ff  <= rsp_green_in;
         rsp_blue_ff   <= rsp_blue_in;
         rsp_packed_ff <= rsp_packed_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bad_index    = rsp_bad_ff;
   assign rsp_red_out      = rsp_red_ff;
   assign rsp_green_out    = rsp_green_ff;
   assign rsp_blue_out     = rsp_blue_ff;
   assign rsp_transp_out   = 1'b0;
   assign rsp_packed_word  = rsp_packed_ff;
   assign rsp_packed_valid = rsp_pvalid_ff;

   // ---------------- assertions ----------------
   // every transfer yields exactly one response, after stage 1 and the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("response missing two cycles after request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("response without a request");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |->
         rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0 &&
         rsp_packed_word == '0 && !rsp_packed_valid)
      else $error("bad index response carries payload");

   a_read_or_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packed_valid |->
         rsp_red_out == '0 && rsp_green_out == '0 && rsp_blue_out == '0)
      else $error("packed word and color on the same response");

   a_pseudo_update: assert property (@(posedge clock) disable iff (reset)
      pseudo_wr |=> pseudo_ff[$past(req_addr[PSEUDO_W-1:0])] ==
                    $past(req_pack.packed_word))
      else $error("pseudo-palette entry not updated");

endmodule
